// File: src/mseu_pkg.sv
// Shared constants, types and decode codes for the MIPS subset execute unit.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package mseu_pkg;

    localparam int unsigned DMEM_WORDS = 1024;
    localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);
    localparam int unsigned RF_DEPTH   = 32;

    typedef logic [31:0] t_word;
    typedef logic [4:0]  t_reg_idx;
    typedef logic [1:0]  t_status;

    localparam t_word RESET_PC      = 32'h0040_0000;
    localparam t_word SYSCALL_EXIT  = 32'd10;
    localparam t_reg_idx REG_V0     = 5'd2;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_UNKNOWN = 2'd1;
    localparam t_status ST_HALT    = 2'd2;
    localparam t_status ST_IGNORED = 2'd3;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;

    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;

    typedef struct packed {
        t_word    executed_pc;
        t_word    next_pc;
        logic     reg_written;
        t_reg_idx dest_index;
        t_word    dest_value;
        logic     mem_stored;
        t_word    mem_byte_address;
        t_status  status;
    } t_result;

endpackage

`default_nettype wire

// File: src/mseu_in_if.sv
// Instruction channel: valid, ready and one instruction word per transaction.
// Depends on mseu_pkg for the word type.
`default_nettype none

interface mseu_in_if
    import mseu_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

`default_nettype wire

// File: src/mseu_out_if.sv
// Result channel: valid, ready and the fields of one executed instruction.
// Depends on mseu_pkg for the field types.
`default_nettype none

interface mseu_out_if
    import mseu_pkg::*;
;
    logic     valid;
    logic     ready;
    t_word    executed_pc;
    t_word    next_pc;
    logic     reg_written;
    t_reg_idx dest_index;
    t_word    dest_value;
    logic     mem_stored;
    t_word    mem_byte_address;
    t_status  status;

    modport source (
        output valid, output executed_pc, output next_pc, output reg_written,
        output dest_index, output dest_value, output mem_stored,
        output mem_byte_address, output status, input ready
    );
    modport sink (
        input valid, input executed_pc, input next_pc, input reg_written,
        input dest_index, input dest_value, input mem_stored,
        input mem_byte_address, input status, output ready
    );
endinterface

`default_nettype wire

// File: src/mips_subset_execute_unit.sv
// MIPS32 integer ALU and load/store word execute unit, top level.
// Depends on mseu_pkg, mseu_in_if and mseu_out_if.
//
// Instructions arrive on i_in, one per transaction, fetched by the user at
// the pc that the previous result reported as next_pc. Each result leaves on
// o_out with the executed and next pc, any register write, any store and the
// status code. The pc is loaded through i_cfg_wr_en and i_cfg_wr_data, which
// are to be used only while no instruction is outstanding.
// An accepted instruction is registered with its two register operands in
// the execute register, is executed there, and its result is registered for
// o_out. One instruction can be accepted in every cycle while the result
// channel does not stall; results of earlier instructions are forwarded,
// and a load's data comes from the data memory's registered read. After
// reset the data memory is cleared one word a cycle; i_in.ready stays low
// until the DMEM_WORDS (1024) words are clear; the register file clears at once.
// When the receiver stalls, the result is held and one further instruction
// may still be accepted into the execute register before i_in.ready falls.
`default_nettype none

module mips_subset_execute_unit
    import mseu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [31:0] i_cfg_wr_data,
    mseu_in_if.sink     i_in,
    mseu_out_if.source  o_out
);

    logic [RF_DEPTH-1:0] r_rf_vld;
    t_word               r_rf [RF_DEPTH];
    t_word               r_reg2;
    t_word               r_dmem [DMEM_WORDS];
    t_word               r_mem_rdata;

    logic                r_clearing;
    logic [DMEM_AW-1:0]  r_clr_idx;

    logic     r_s1_v;
    t_word    r_s1_iw;
    t_word    r_rd_a;
    t_word    r_rd_b;
    t_word    r_rd_2;
    t_word    r_pc;
    logic     r_halted;

    logic     r_s2_v;
    logic     r_s2_new;
    logic     r_s2_load;
    t_result  r_s2;

    logic     in_acc;
    logic     s1_adv;
    logic     rf_we;
    t_word    s2_wdata;
    t_word    n_rd_a;
    t_word    n_rd_b;
    t_word    n_rd_2;
    t_reg_idx in_rs;
    t_reg_idx in_rt;

    logic [5:0] op;
    logic [5:0] fn;
    t_reg_idx   rs;
    t_reg_idx   rt;
    t_reg_idx   rd;
    t_word      zimm;
    t_word      simm;
    t_word      opa;
    t_word      opb;
    t_word      reg2;

    t_result    n_s2;
    logic       s1_load;
    logic       s1_halt;
    logic [DMEM_AW-1:0] s1_widx;

    assign s1_adv   = r_s1_v && (!r_s2_v || o_out.ready);
    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = !r_clearing && (!r_s1_v || s1_adv);

    assign s2_wdata = r_s2_load ? r_mem_rdata : r_s2.dest_value;
    assign rf_we    = r_s2_v && r_s2_new && r_s2.reg_written;

    assign in_rs = i_in.instruction_word[25:21];
    assign in_rt = i_in.instruction_word[20:16];

    always_comb begin
        if (rf_we && r_s2.dest_index == in_rs) begin
            n_rd_a = s2_wdata;
        end else begin
            n_rd_a = r_rf_vld[in_rs] ? r_rf[in_rs] : '0;
        end
        if (rf_we && r_s2.dest_index == in_rt) begin
            n_rd_b = s2_wdata;
        end else begin
            n_rd_b = r_rf_vld[in_rt] ? r_rf[in_rt] : '0;
        end
        if (rf_we && r_s2.dest_index == REG_V0) begin
            n_rd_2 = s2_wdata;
        end else begin
            n_rd_2 = r_reg2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[r_s2.dest_index] <= s2_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_reg2   <= '0;
        end else if (rf_we) begin
            r_rf_vld[r_s2.dest_index] <= 1'b1;
            if (r_s2.dest_index == REG_V0) begin
                r_reg2 <= s2_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_iw <= i_in.instruction_word;
            r_rd_a  <= n_rd_a;
            r_rd_b  <= n_rd_b;
            r_rd_2  <= n_rd_2;
        end
    end

    // The instruction in the result register is the one just before the one
    // in the execute register, and its register write may not have landed.
    always_comb begin
        op   = r_s1_iw[31:26];
        rs   = r_s1_iw[25:21];
        rt   = r_s1_iw[20:16];
        rd   = r_s1_iw[15:11];
        fn   = r_s1_iw[5:0];
        zimm = {16'h0000, r_s1_iw[15:0]};
        simm = {{16{r_s1_iw[15]}}, r_s1_iw[15:0]};
        opa  = r_rd_a;
        opb  = r_rd_b;
        reg2 = r_rd_2;
        if (r_s2_v && r_s2.reg_written) begin
            if (r_s2.dest_index == rs) begin
                opa = s2_wdata;
            end
            if (r_s2.dest_index == rt) begin
                opb = s2_wdata;
            end
            if (r_s2.dest_index == REG_V0) begin
                reg2 = s2_wdata;
            end
        end
    end

    always_comb begin
        n_s2             = '0;
        n_s2.executed_pc = r_pc;
        n_s2.status      = ST_OK;
        s1_load          = 1'b0;
        s1_halt          = 1'b0;
        if (r_halted) begin
            n_s2.next_pc = r_pc;
            n_s2.status  = ST_IGNORED;
        end else begin
            n_s2.next_pc = r_pc + 32'd4;
            if (op == OP_SPECIAL) begin
                n_s2.dest_index  = rd;
                n_s2.reg_written = 1'b1;
                case (fn)
                    FN_ADD, FN_ADDU: n_s2.dest_value = opa + opb;
                    FN_SUB, FN_SUBU: n_s2.dest_value = opa - opb;
                    FN_AND:  n_s2.dest_value = opa & opb;
                    FN_OR:   n_s2.dest_value = opa | opb;
                    FN_XOR:  n_s2.dest_value = opa ^ opb;
                    FN_NOR:  n_s2.dest_value = ~(opa | opb);
                    FN_SLT:  n_s2.dest_value = {31'd0, $signed(opa) < $signed(opb)};
                    FN_SLTU: n_s2.dest_value = {31'd0, opa < opb};
                    FN_SYSCALL: begin
                        n_s2.reg_written = 1'b0;
                        if (reg2 == SYSCALL_EXIT) begin
                            s1_halt     = 1'b1;
                            n_s2.status = ST_HALT;
                        end
                    end
                    default: begin
                        n_s2.reg_written = 1'b0;
                        n_s2.status      = ST_UNKNOWN;
                    end
                endcase
            end else if (op inside {[OP_ADDI:OP_LUI]}) begin
                n_s2.dest_index  = rt;
                n_s2.reg_written = 1'b1;
                case (op)
                    OP_ADDI, OP_ADDIU: n_s2.dest_value = opa + simm;
                    OP_SLTI:  n_s2.dest_value = {31'd0, $signed(opa) < $signed(simm)};
                    OP_SLTIU: n_s2.dest_value = {31'd0, opa < simm};
                    OP_ANDI:  n_s2.dest_value = opa & zimm;
                    OP_ORI:   n_s2.dest_value = opa | zimm;
                    OP_XORI:  n_s2.dest_value = opa ^ zimm;
                    default:  n_s2.dest_value = {r_s1_iw[15:0], 16'h0000};
                endcase
            end else if (op == OP_LW) begin
                n_s2.mem_byte_address = opa + simm;
                n_s2.dest_index       = rt;
                n_s2.reg_written      = 1'b1;
                s1_load               = 1'b1;
            end else if (op == OP_SW) begin
                n_s2.mem_byte_address = opa + simm;
                n_s2.mem_stored       = 1'b1;
            end else begin
                n_s2.status = ST_UNKNOWN;
            end
        end
        if (!n_s2.reg_written || n_s2.dest_index == '0) begin
            n_s2.reg_written = 1'b0;
            n_s2.dest_index  = '0;
            n_s2.dest_value  = '0;
            s1_load          = 1'b0;
        end
    end

    assign s1_widx = n_s2.mem_byte_address[DMEM_AW+1:2];

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_dmem[r_clr_idx] <= '0;
        end else if (s1_adv && n_s2.mem_stored) begin
            r_dmem[s1_widx] <= opb;
        end
        if (s1_adv && s1_load) begin
            r_mem_rdata <= r_dmem[s1_widx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == DMEM_AW'(DMEM_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s2_new <= 1'b0;
            r_pc     <= RESET_PC;
            r_halted <= 1'b0;
        end else begin
            r_s2_new <= s1_adv;
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (o_out.ready) begin
                r_s2_v <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_pc <= i_cfg_wr_data;
            end else if (s1_adv) begin
                r_pc <= n_s2.next_pc;
            end
            if (s1_adv && s1_halt) begin
                r_halted <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2      <= n_s2;
            r_s2_load <= s1_load;
        end
    end

    assign o_out.valid            = r_s2_v;
    assign o_out.executed_pc      = r_s2.executed_pc;
    assign o_out.next_pc          = r_s2.next_pc;
    assign o_out.reg_written      = r_s2.reg_written;
    assign o_out.dest_index       = r_s2.dest_index;
    assign o_out.dest_value       = s2_wdata;
    assign o_out.mem_stored       = r_s2.mem_stored;
    assign o_out.mem_byte_address = r_s2.mem_byte_address;
    assign o_out.status           = r_s2.status;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_in.ready)
        else $error("instruction accepted during data memory clear");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted state left without reset");

    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.reg_written |-> o_out.dest_index != '0)
        else $error("register zero reported as written");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_IGNORED |->
            !o_out.reg_written && !o_out.mem_stored &&
            o_out.next_pc == o_out.executed_pc)
        else $error("ignored instruction had an effect");

    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != ST_IGNORED |->
            o_out.next_pc == o_out.executed_pc + 32'd4)
        else $error("next pc is not executed pc plus four");

endmodule

`default_nettype wire

// File: test/mseu_result_checker.sv
// Result checker for the MIPS subset execute unit: predicts each result from the
// accepted instructions and compares it with what leaves the result channel.
// Depends on mseu_pkg, mseu_in_if and mseu_out_if.
`default_nettype none

module mseu_result_checker
    import mseu_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire [31:0] i_cfg_wr_data,
    mseu_in_if         i_in,
    mseu_out_if        i_out,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_unknown,
    output int         o_ignored
);

    localparam int MAX_REPORTS = 10;

    t_word   gpr [RF_DEPTH];
    t_word   dmem [DMEM_WORDS];
    t_word   pc;
    logic    halted;
    t_result pending_results [$];

    function automatic t_result execute_instruction(input t_word w);
        logic [5:0] op;
        logic [5:0] fn;
        t_reg_idx   rs;
        t_reg_idx   rt;
        t_reg_idx   rd;
        t_word      simm;
        t_word      zimm;
        t_word      a;
        t_word      b;
        t_word      val;
        t_reg_idx   dst;
        logic       wr;
        t_result    r;
        op   = w[31:26];
        rs   = w[25:21];
        rt   = w[20:16];
        rd   = w[15:11];
        fn   = w[5:0];
        simm = {{16{w[15]}}, w[15:0]};
        zimm = {16'd0, w[15:0]};
        a    = gpr[rs];
        b    = gpr[rt];
        r    = '0;
        wr   = 1'b0;
        dst  = '0;
        val  = '0;
        r.executed_pc = pc;
        if (halted) begin
            r.next_pc = pc;
            r.status  = ST_IGNORED;
            return r;
        end
        r.next_pc = pc + 32'd4;
        r.status  = ST_OK;
        case (op)
            OP_SPECIAL: begin
                wr  = 1'b1;
                dst = rd;
                case (fn)
                    FN_ADD, FN_ADDU: val = a + b;
                    FN_SUB, FN_SUBU: val = a - b;
                    FN_AND:          val = a & b;
                    FN_OR:           val = a | b;
                    FN_XOR:          val = a ^ b;
                    FN_NOR:          val = ~(a | b);
                    FN_SLT:          val = {31'd0, ($signed(a) < $signed(b))};
                    FN_SLTU:         val = {31'd0, (a < b)};
                    FN_SYSCALL: begin
                        wr = 1'b0;
                        if (gpr[REG_V0] == SYSCALL_EXIT) begin
                            halted   = 1'b1;
                            r.status = ST_HALT;
                        end
                    end
                    default: begin
                        wr       = 1'b0;
                        r.status = ST_UNKNOWN;
                    end
                endcase
            end
            OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
                wr  = 1'b1;
                dst = rt;
                case (op)
                    OP_SLTI:  val = {31'd0, ($signed(a) < $signed(simm))};
                    OP_SLTIU: val = {31'd0, (a < simm)};
                    OP_ANDI:  val = a & zimm;
                    OP_ORI:   val = a | zimm;
                    OP_XORI:  val = a ^ zimm;
                    OP_LUI:   val = {w[15:0], 16'd0};
                    default:  val = a + simm;
                endcase
            end
            OP_LW: begin
                r.mem_byte_address = a + simm;
                wr  = 1'b1;
                dst = rt;
                val = dmem[(r.mem_byte_address >> 2) % DMEM_WORDS];
            end
            OP_SW: begin
                r.mem_byte_address = a + simm;
                dmem[(r.mem_byte_address >> 2) % DMEM_WORDS] = b;
                r.mem_stored = 1'b1;
            end
            default: r.status = ST_UNKNOWN;
        endcase
        // A write aimed at register zero is dropped and reported as no write.
        if (wr && dst != '0) begin
            gpr[dst]      = val;
            r.reg_written = 1'b1;
            r.dest_index  = dst;
            r.dest_value  = val;
        end
        pc = r.next_pc;
        return r;
    endfunction

    task automatic compare_field(input string field, input t_word at_pc, input t_word want,
                                 input t_word got);
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= MAX_REPORTS) begin
                $display("Mismatch in %s for pc %h: expected %h, got %h",
                         field, at_pc, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : track
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            foreach (gpr[k]) gpr[k] = '0;
            foreach (dmem[k]) dmem[k] = '0;
            pc     = RESET_PC;
            halted = 1'b0;
            pending_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_unknown    = 0;
            o_ignored    = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.executed_pc      = i_out.executed_pc;
                got.next_pc          = i_out.next_pc;
                got.reg_written      = i_out.reg_written;
                got.dest_index       = i_out.dest_index;
                got.dest_value       = i_out.dest_value;
                got.mem_stored       = i_out.mem_stored;
                got.mem_byte_address = i_out.mem_byte_address;
                got.status           = i_out.status;
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("Result transaction for pc %h with no instruction outstanding",
                                 got.executed_pc);
                    end
                end else begin
                    want = pending_results.pop_front();
                    compare_field("executed_pc", want.executed_pc, want.executed_pc,
                                  got.executed_pc);
                    compare_field("next_pc", want.executed_pc, want.next_pc, got.next_pc);
                    compare_field("reg_written", want.executed_pc, want.reg_written,
                                  got.reg_written);
                    compare_field("dest_index", want.executed_pc, want.dest_index,
                                  got.dest_index);
                    compare_field("dest_value", want.executed_pc, want.dest_value,
                                  got.dest_value);
                    compare_field("mem_stored", want.executed_pc, want.mem_stored,
                                  got.mem_stored);
                    compare_field("mem_byte_address", want.executed_pc, want.mem_byte_address,
                                  got.mem_byte_address);
                    compare_field("status", want.executed_pc, want.status, got.status);
                    o_checked++;
                    if (want.status == ST_UNKNOWN) o_unknown++;
                    if (want.status == ST_IGNORED) o_ignored++;
                end
            end
            if (i_cfg_wr_en) pc = i_cfg_wr_data;
            if (i_in.valid && i_in.ready) begin
                pending_results.push_back(execute_instruction(i_in.instruction_word));
            end
        end
        o_pending = pending_results.size();
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
// Top level of the execute unit testbench: clock, reset, instruction stimulus,
// result back-pressure, start pc writes, watchdog and the final verdict.
// Depends on mseu_pkg, both channel interfaces, the block and mseu_result_checker.
`default_nettype none

module testbench;
    import mseu_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;

    // Encodings outside the supported subset.
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_LB    = 6'd32;
    localparam logic [5:0] OP_LH    = 6'd33;
    localparam logic [5:0] OP_LBU   = 6'd36;
    localparam logic [5:0] OP_LHU   = 6'd37;
    localparam logic [5:0] OP_SB    = 6'd40;
    localparam logic [5:0] OP_SH    = 6'd41;
    localparam logic [5:0] FN_BREAK = 6'd13;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_wr_en;
    t_word cfg_wr_data;
    logic  gaps_on;
    int    fail_count;
    int    pending;
    int    checked;
    int    unknown;
    int    ignored;
    int    sent;
    int    idle_cycles;

    mseu_in_if  in_ch ();
    mseu_out_if out_ch ();

    mips_subset_execute_unit DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch.sink),
        .o_out         (out_ch.source)
    );

    mseu_result_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_unknown     (unknown),
        .o_ignored     (ignored)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 22);
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("mips_subset_execute_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_word r_word(input logic [5:0] fn, input t_reg_idx rd,
                                     input t_reg_idx rs, input t_reg_idx rt);
        return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic t_word i_word(input logic [5:0] op, input t_reg_idx rt,
                                     input t_reg_idx rs, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic t_word syscall_word();
        return {OP_SPECIAL, 20'($urandom), FN_SYSCALL};
    endfunction

    // Mostly low registers, so that back-to-back instructions depend on each other.
    function automatic t_reg_idx pick_reg();
        if ($urandom_range(0, 99) < 75) return t_reg_idx'($urandom_range(0, 7));
        return t_reg_idx'($urandom_range(0, 31));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_word random_instruction();
        t_word       w;
        int unsigned kind;
        logic [5:0]  op;
        logic [5:0]  fn;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            case ($urandom_range(0, 9))
                0:       fn = FN_ADD;
                1:       fn = FN_ADDU;
                2:       fn = FN_SUB;
                3:       fn = FN_SUBU;
                4:       fn = FN_AND;
                5:       fn = FN_OR;
                6:       fn = FN_XOR;
                7:       fn = FN_NOR;
                8:       fn = FN_SLT;
                default: fn = FN_SLTU;
            endcase
            w = r_word(fn, pick_reg(), pick_reg(), pick_reg());
            w[10:6] = 5'($urandom);
        end else if (kind < 65) begin
            op = 6'($urandom_range(OP_LUI, OP_ADDI));
            w = i_word(op, pick_reg(), pick_reg(), pick_imm());
        end else if (kind < 88) begin
            op = $urandom_range(0, 1) ? OP_LW : OP_SW;
            // Addresses near zero from register zero, so that loads see earlier stores.
            if ($urandom_range(0, 3) != 0) begin
                w = i_word(op, pick_reg(), '0, 16'($urandom_range(0, 255)) - 16'd128);
            end else begin
                w = i_word(op, pick_reg(), pick_reg(), pick_imm());
            end
        end else if (kind < 94) begin
            case ($urandom_range(0, 2))
                0: begin
                    case ($urandom_range(0, 5))
                        0:       op = OP_LB;
                        1:       op = OP_LH;
                        2:       op = OP_LBU;
                        3:       op = OP_LHU;
                        4:       op = OP_SB;
                        default: op = OP_SH;
                    endcase
                    w = i_word(op, pick_reg(), pick_reg(), pick_imm());
                end
                1:       w = {OP_SPECIAL, 20'($urandom), 6'($urandom)};
                default: w = {6'($urandom), 26'($urandom)};
            endcase
        end else begin
            w = $urandom;
        end
        // A system call is only issued with register 2 set just before it.
        if (w[31:26] == OP_SPECIAL && w[5:0] == FN_SYSCALL) w[5:0] = FN_BREAK;
        return w;
    endfunction

    task automatic send(input t_word word);
        while (gaps_on && $urandom_range(0, 99) < 22) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.instruction_word <= word;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_start_pc(input t_word value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random(input int count);
        logic [15:0] v0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 4) begin
                v0 = 16'($urandom);
                if (v0 == 16'(SYSCALL_EXIT)) v0 = v0 + 16'd1;
                send(i_word(OP_ORI, REG_V0, '0, v0));
                send(syscall_word());
            end else begin
                send(random_instruction());
            end
        end
    endtask

    initial begin : stimulus
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        in_ch.valid            = 1'b0;
        in_ch.instruction_word = '0;
        out_ch.ready           = 1'b0;
        gaps_on                = 1'b1;
        sent                   = 0;
        idle_cycles            = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset pc: extremes, wrapping sums, every operation.
        send(i_word(OP_LUI, 5'd1, 5'd0, 16'h7FFF));
        send(i_word(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
        send(i_word(OP_ADDIU, 5'd2, 5'd0, 16'hFFFF));
        send(i_word(OP_ADDI, 5'd5, 5'd1, 16'h0001));
        send(r_word(FN_ADD, 5'd3, 5'd1, 5'd1));
        send(r_word(FN_ADDU, 5'd4, 5'd2, 5'd2));
        send(r_word(FN_SUB, 5'd6, 5'd5, 5'd1));
        send(r_word(FN_SUBU, 5'd7, 5'd0, 5'd5));
        send(r_word(FN_AND, 5'd8, 5'd1, 5'd2));
        send(r_word(FN_OR, 5'd9, 5'd1, 5'd5));
        send(r_word(FN_XOR, 5'd10, 5'd2, 5'd1));
        send(r_word(FN_NOR, 5'd11, 5'd0, 5'd0));
        send(r_word(FN_SLT, 5'd12, 5'd5, 5'd1));
        send(r_word(FN_SLTU, 5'd13, 5'd5, 5'd1));
        send(i_word(OP_SLTI, 5'd14, 5'd1, 16'h8000));
        send(i_word(OP_SLTIU, 5'd15, 5'd1, 16'hFFFF));
        send(i_word(OP_ANDI, 5'd16, 5'd2, 16'h8000));
        send(i_word(OP_XORI, 5'd17, 5'd2, 16'hFFFF));
        send(i_word(OP_SW, 5'd5, 5'd0, 16'hFFFC));
        send(i_word(OP_LW, 5'd18, 5'd0, 16'h0FFF));
        send(i_word(OP_LW, 5'd0, 5'd0, 16'h0FFC));
        send(r_word(FN_ADDU, 5'd0, 5'd2, 5'd2));
        send(i_word(OP_LB, 5'd19, 5'd0, 16'h0000));
        send({OP_J, 26'h3FF_FFFF});
        send(r_word(FN_BREAK, 5'd20, 5'd1, 5'd2));
        send(i_word(OP_ORI, REG_V0, 5'd0, 16'd9));
        send(syscall_word());

        // Random phases, each from its own start pc; the first one wraps past zero.
        write_start_pc(32'hFFFF_FFF0);
        run_random(350);
        write_start_pc(32'h0000_0000);
        gaps_on = 1'b0;
        run_random(350);
        gaps_on = 1'b1;
        write_start_pc($urandom);
        run_random(350);
        write_start_pc(32'hFFFF_FFFF);
        run_random(350);

        // Halt, then instructions that are ignored, also after a new start pc.
        write_start_pc($urandom);
        run_random(100);
        send(i_word(OP_ORI, REG_V0, 5'd0, 16'(SYSCALL_EXIT)));
        send(syscall_word());
        repeat (12) send($urandom);
        write_start_pc($urandom);
        repeat (12) send($urandom);

        drain();
        repeat (8) @(negedge clk);
        $display("Sent %0d instructions under seven start pcs; %0d results checked,",
                 sent, checked);
        $display("of which %0d were unknown encodings and %0d were ignored after the halt.",
                 unknown, ignored);
        if (fail_count == 0 && pending == 0) begin
            $display("mips_subset_execute_unit test passed");
        end else begin
            $display("mips_subset_execute_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
src/mseu_pkg.sv
src/mseu_in_if.sv
src/mseu_out_if.sv
src/mips_subset_execute_unit.sv
test/mseu_result_checker.sv
test/testbench.sv
